// ===== rtl/itmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmh_pkg
// Shared constants, codes and controller/datapath interface types for the
// indexed timer min-heap.
// ----------------------------------------------------------------------------
package itmh_pkg;

   localparam int HEAP_CAPACITY = 32;
   localparam int ID_SPACE      = 256;
   localparam int EXPIRE_BURST  = 32;
   localparam int BURST_W       = $clog2(EXPIRE_BURST + 1);

   localparam logic [23:0] NEXT_WAIT_MAX = 24'hFFFFFF;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_FIRE   = 3'd2;
   localparam logic [2:0] OP_EXPIRE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   typedef enum logic [1:0] {
      KIND_FIRED   = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_UNKNOWN = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RA_ROOT   = 2'd0,
      RA_PARENT = 2'd1,
      RA_CHILD  = 2'd2,
      RA_S0     = 2'd3
   } rd_a_sel_type;

   typedef enum logic {
      RB_SIBLING = 1'b0,
      RB_TAIL    = 1'b1
   } rd_b_sel_type;

   typedef struct packed {
      logic         in_ready;
      logic         load;
      rd_a_sel_type rd_a_sel;
      rd_b_sel_type rd_b_sel;
      logic         start_known;
      logic         start_insert;
      logic         start_fire;
      logic         start_expire;
      logic         move_parent;
      logic         write_cur;
      logic         load_cur_s0;
      logic         move_child;
      logic         remove;
      logic         clear_all;
      logic         set_kind;
      kind_type     kind;
      logic         set_nw;
      logic         emit_final;
      logic         emit_report;
   } cmd_type;

   typedef struct packed {
      logic       in_valid;
      logic [2:0] op;
      logic       known;
      logic       in_range;
      logic       full;
      logic       hole_zero;
      logic       up_stop;
      logic       dn_leaf;
      logic       dn_stop;
      logic       rm_has_tail;
      logic       exp_more;
      logic       out_free;
   } status_type;

   function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

// ===== rtl/itmh_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmh_stream_if
// Request and response channels of the timer heap, valid/ready handshake.
// ----------------------------------------------------------------------------
interface itmh_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [7:0]  timer_id;
   logic [23:0] wait_ms;
   logic [31:0] now_ms;

   modport source (output valid, output op, output timer_id, output wait_ms,
                   output now_ms, input ready);
   modport sink (input valid, input op, input timer_id, input wait_ms,
                 input now_ms, output ready);
endinterface

interface itmh_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         fired_id;
   logic signed [24:0] next_wait;
   logic               last;

   modport source (output valid, output kind, output fired_id, output next_wait,
                   output last, input ready);
   modport sink (input valid, input kind, input fired_id, input next_wait,
                 input last, output ready);
endinterface

// ===== rtl/itmh_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmh_datapath
// Heap memories, id-to-slot table, presence bits, sift registers and the
// result register.
// ----------------------------------------------------------------------------
module itmh_datapath #(
   parameter int HEAP_CAPACITY = itmh_pkg::HEAP_CAPACITY,
   parameter int ID_SPACE      = itmh_pkg::ID_SPACE
) (
   input  logic                 clock,
   input  logic                 reset,
   itmh_req_if.sink             req,
   itmh_rsp_if.source           rsp,
   input  itmh_pkg::cmd_type    cmd,
   output itmh_pkg::status_type status
);

   localparam int SLOT_W = $clog2(HEAP_CAPACITY);
   localparam int CNT_W  = $clog2(HEAP_CAPACITY + 1);
   localparam int IDX_W  = $clog2(ID_SPACE);
   localparam int CH_W   = SLOT_W + 2;
   localparam int BW     = itmh_pkg::BURST_W;

   logic [7:0]  heap_id_mem  [HEAP_CAPACITY];
   logic [31:0] heap_exp_mem [HEAP_CAPACITY];
   logic [SLOT_W-1:0] slot_mem [ID_SPACE];

   logic [2:0]         op_ff;
   logic [7:0]         tid_ff;
   logic [31:0]        now_ff;
   logic [31:0]        exp_ff;
   logic [7:0]         cur_id_ff;
   logic [31:0]        cur_exp_ff;
   logic [SLOT_W-1:0]  hole_ff;
   logic [SLOT_W-1:0]  s0_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [BW-1:0]      n_ff;
   itmh_pkg::kind_type res_kind_ff;
   logic signed [24:0] nw_ff;
   logic [ID_SPACE-1:0] present_ff;
   logic [7:0]         rd_a_id_ff;
   logic [31:0]        rd_a_exp_ff;
   logic [7:0]         rd_b_id_ff;
   logic [31:0]        rd_b_exp_ff;
   logic [SLOT_W-1:0]  slot_rd_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_kind_ff;
   logic [7:0]         rsp_id_ff;
   logic signed [24:0] rsp_nw_ff;
   logic               rsp_last_ff;

   logic [IDX_W-1:0]  tid_idx;
   logic [SLOT_W-1:0] parent;
   logic [CH_W-1:0]   child_c;
   logic [CH_W-1:0]   child_b;
   logic [CH_W-1:0]   count_x;
   logic              pick_b;
   logic [SLOT_W-1:0] pick_slot;
   logic [7:0]        pick_id;
   logic [31:0]       pick_exp;
   logic [SLOT_W-1:0] rd_a_addr;
   logic [SLOT_W-1:0] rd_b_addr;
   logic              wr_en;
   logic [7:0]        wr_id;
   logic [31:0]       wr_exp;
   logic [31:0]       diff;
   logic              due;
   logic signed [24:0] nw_calc;
   logic              out_free;

   assign tid_idx = IDX_W'(tid_ff);
   assign parent  = SLOT_W'((hole_ff - 1'b1) >> 1);
   assign child_c = {1'b0, hole_ff, 1'b1};
   assign child_b = child_c + 1'b1;
   assign count_x = CH_W'(count_ff);

   assign pick_b    = (child_b < count_x) && itmh_pkg::earlier(rd_b_exp_ff, rd_a_exp_ff);
   assign pick_slot = pick_b ? SLOT_W'(child_b) : SLOT_W'(child_c);
   assign pick_id   = pick_b ? rd_b_id_ff : rd_a_id_ff;
   assign pick_exp  = pick_b ? rd_b_exp_ff : rd_a_exp_ff;

   always_comb begin
      case (cmd.rd_a_sel)
         itmh_pkg::RA_ROOT:   rd_a_addr = '0;
         itmh_pkg::RA_PARENT: rd_a_addr = parent;
         itmh_pkg::RA_CHILD:  rd_a_addr = SLOT_W'(child_c);
         default:             rd_a_addr = s0_ff;
      endcase
      case (cmd.rd_b_sel)
         itmh_pkg::RB_TAIL: rd_b_addr = SLOT_W'(count_ff - 1'b1);
         default:           rd_b_addr = SLOT_W'(child_b);
      endcase
   end

   always_comb begin
      wr_en  = cmd.write_cur | cmd.move_parent | cmd.move_child;
      wr_id  = cur_id_ff;
      wr_exp = cur_exp_ff;
      if (cmd.move_parent) begin
         wr_id  = rd_a_id_ff;
         wr_exp = rd_a_exp_ff;
      end else if (cmd.move_child) begin
         wr_id  = pick_id;
         wr_exp = pick_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_id_mem[hole_ff]     <= wr_id;
         heap_exp_mem[hole_ff]    <= wr_exp;
         slot_mem[IDX_W'(wr_id)]  <= hole_ff;
      end
      rd_a_id_ff  <= heap_id_mem[rd_a_addr];
      rd_a_exp_ff <= heap_exp_mem[rd_a_addr];
      rd_b_id_ff  <= heap_id_mem[rd_b_addr];
      rd_b_exp_ff <= heap_exp_mem[rd_b_addr];
      slot_rd_ff  <= slot_mem[tid_idx];
   end

   assign diff = rd_a_exp_ff - now_ff;
   assign due  = (diff == '0) || diff[31];

   always_comb begin
      if (count_ff == '0)
         nw_calc = '1;
      else if (due)
         nw_calc = '0;
      else if (diff > {8'd0, itmh_pkg::NEXT_WAIT_MAX})
         nw_calc = 25'({1'b0, itmh_pkg::NEXT_WAIT_MAX});
      else
         nw_calc = diff[24:0];
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req.op;
         tid_ff <= req.timer_id;
         now_ff <= req.now_ms;
         exp_ff <= req.now_ms + 32'(req.wait_ms);
         nw_ff  <= '0;
      end
      if (cmd.set_kind) res_kind_ff <= cmd.kind;
      if (cmd.set_nw) nw_ff <= nw_calc;
      if (cmd.start_known) begin
         cur_id_ff  <= tid_ff;
         cur_exp_ff <= exp_ff;
         hole_ff    <= slot_rd_ff;
         s0_ff      <= slot_rd_ff;
      end
      if (cmd.start_insert) begin
         cur_id_ff  <= tid_ff;
         cur_exp_ff <= exp_ff;
         hole_ff    <= SLOT_W'(count_ff);
      end
      if (cmd.start_fire) s0_ff <= slot_rd_ff;
      if (cmd.start_expire || cmd.emit_report) s0_ff <= '0;
      if (cmd.start_expire) n_ff <= '0;
      if (cmd.emit_report) n_ff <= n_ff + 1'b1;
      if (cmd.move_parent) hole_ff <= parent;
      if (cmd.move_child) hole_ff <= pick_slot;
      if (cmd.load_cur_s0) begin
         cur_id_ff  <= rd_a_id_ff;
         cur_exp_ff <= rd_a_exp_ff;
         hole_ff    <= s0_ff;
      end
      if (cmd.remove) begin
         cur_id_ff  <= rd_b_id_ff;
         cur_exp_ff <= rd_b_exp_ff;
         hole_ff    <= s0_ff;
      end
      if (cmd.emit_report || cmd.emit_final) begin
         rsp_kind_ff <= cmd.emit_report ? itmh_pkg::KIND_FIRED : res_kind_ff;
         rsp_id_ff   <= cmd.emit_report ? rd_a_id_ff : tid_ff;
         rsp_nw_ff   <= cmd.emit_report ? '0 : nw_ff;
         rsp_last_ff <= cmd.emit_final;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_all) begin
            count_ff   <= '0;
            present_ff <= '0;
         end else if (cmd.start_insert) begin
            count_ff            <= count_ff + 1'b1;
            present_ff[tid_idx] <= 1'b1;
         end else if (cmd.remove) begin
            count_ff                         <= count_ff - 1'b1;
            present_ff[IDX_W'(rd_a_id_ff)]   <= 1'b0;
         end
         if (cmd.emit_report || cmd.emit_final)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   assign req.ready     = cmd.in_ready && !reset;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.fired_id  = rsp_id_ff;
   assign rsp.next_wait = rsp_nw_ff;
   assign rsp.last      = rsp_last_ff;

   always_comb begin
      status.in_valid    = req.valid;
      status.op          = op_ff;
      status.in_range    = 32'(tid_ff) < 32'(ID_SPACE);
      status.known       = status.in_range && present_ff[tid_idx];
      status.full        = count_ff >= CNT_W'(HEAP_CAPACITY);
      status.hole_zero   = hole_ff == '0;
      status.up_stop     = itmh_pkg::earlier(rd_a_exp_ff, cur_exp_ff);
      status.dn_leaf     = child_c >= count_x;
      status.dn_stop     = itmh_pkg::earlier(cur_exp_ff, pick_exp);
      status.rm_has_tail = (CNT_W'(s0_ff) + 1'b1) < count_ff;
      status.exp_more    = (count_ff != '0) && (n_ff < BW'(itmh_pkg::EXPIRE_BURST)) && due;
      status.out_free    = out_free;
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_report || cmd.emit_final) |-> out_free)
      else $error("result written while output register busy");
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start_insert, cmd.remove, cmd.clear_all}))
      else $error("conflicting count updates");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_CAPACITY))
      else $error("heap count above capacity");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.start_insert |-> !status.full)
      else $error("insert into full heap");

endmodule

// ===== rtl/itmh_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itmh_controller
// Sequencer for lookup, sift-up, sift-down, removal and expire bursts.
// ----------------------------------------------------------------------------
module itmh_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  itmh_pkg::status_type status,
   output itmh_pkg::cmd_type    cmd
);

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_LOOK     = 16'h0002,
      S_DISPATCH = 16'h0004,
      S_UP_RD    = 16'h0008,
      S_UP_CMP   = 16'h0010,
      S_UP_END   = 16'h0020,
      S_DN_LD    = 16'h0040,
      S_DN_LD2   = 16'h0080,
      S_DN_RD    = 16'h0100,
      S_DN_CMP   = 16'h0200,
      S_DN_END   = 16'h0400,
      S_RM_RD    = 16'h0800,
      S_RM_CMP   = 16'h1000,
      S_EXP_RD   = 16'h2000,
      S_EXP_CHK  = 16'h4000,
      S_FINAL    = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      sink_ff, sink_in;
   state_type after_state;

   assign after_state = (status.op == itmh_pkg::OP_EXPIRE) ? S_EXP_RD : S_FINAL;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      sink_in  = sink_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.in_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: state_in = S_DISPATCH;
         S_DISPATCH: begin
            cmd.set_kind = 1'b1;
            cmd.kind     = itmh_pkg::KIND_DONE;
            state_in     = S_FINAL;
            case (status.op) inside
               itmh_pkg::OP_ADD, itmh_pkg::OP_UPDATE: begin
                  if (status.known) begin
                     cmd.start_known = 1'b1;
                     sink_in         = 1'b1;
                     state_in        = S_UP_RD;
                  end else if (status.op == itmh_pkg::OP_UPDATE || !status.in_range) begin
                     cmd.kind = itmh_pkg::KIND_UNKNOWN;
                  end else if (status.full) begin
                     cmd.kind = itmh_pkg::KIND_FULL;
                  end else begin
                     cmd.start_insert = 1'b1;
                     sink_in          = 1'b0;
                     state_in         = S_UP_RD;
                  end
               end
               itmh_pkg::OP_FIRE: begin
                  if (status.known) begin
                     cmd.kind       = itmh_pkg::KIND_FIRED;
                     cmd.start_fire = 1'b1;
                     state_in       = S_RM_RD;
                  end else begin
                     cmd.kind = itmh_pkg::KIND_UNKNOWN;
                  end
               end
               itmh_pkg::OP_EXPIRE: begin
                  cmd.start_expire = 1'b1;
                  state_in         = S_EXP_RD;
               end
               itmh_pkg::OP_CLEAR: cmd.clear_all = 1'b1;
               default: ;
            endcase
         end
         S_UP_RD: begin
            cmd.rd_a_sel = itmh_pkg::RA_PARENT;
            state_in     = status.hole_zero ? S_UP_END : S_UP_CMP;
         end
         S_UP_CMP: begin
            if (status.up_stop) begin
               state_in = S_UP_END;
            end else begin
               cmd.move_parent = 1'b1;
               state_in        = S_UP_RD;
            end
         end
         S_UP_END: begin
            cmd.write_cur = 1'b1;
            state_in      = sink_ff ? S_DN_LD : S_FINAL;
         end
         S_DN_LD: begin
            cmd.rd_a_sel = itmh_pkg::RA_S0;
            state_in     = S_DN_LD2;
         end
         S_DN_LD2: begin
            cmd.load_cur_s0 = 1'b1;
            state_in        = S_DN_RD;
         end
         S_DN_RD: begin
            cmd.rd_a_sel = itmh_pkg::RA_CHILD;
            cmd.rd_b_sel = itmh_pkg::RB_SIBLING;
            state_in     = status.dn_leaf ? S_DN_END : S_DN_CMP;
         end
         S_DN_CMP: begin
            if (status.dn_stop) begin
               state_in = S_DN_END;
            end else begin
               cmd.move_child = 1'b1;
               state_in       = S_DN_RD;
            end
         end
         S_DN_END: begin
            cmd.write_cur = 1'b1;
            state_in      = after_state;
         end
         S_RM_RD: begin
            cmd.rd_a_sel = itmh_pkg::RA_S0;
            cmd.rd_b_sel = itmh_pkg::RB_TAIL;
            state_in     = S_RM_CMP;
         end
         S_RM_CMP: begin
            cmd.remove = 1'b1;
            if (status.rm_has_tail) begin
               sink_in  = 1'b1;
               state_in = S_UP_RD;
            end else begin
               state_in = after_state;
            end
         end
         S_EXP_RD: begin
            cmd.rd_a_sel = itmh_pkg::RA_ROOT;
            state_in     = S_EXP_CHK;
         end
         S_EXP_CHK: begin
            cmd.rd_a_sel = itmh_pkg::RA_ROOT;
            if (status.exp_more) begin
               if (status.out_free) begin
                  cmd.emit_report = 1'b1;
                  state_in        = S_RM_RD;
               end
            end else begin
               cmd.set_nw = 1'b1;
               state_in   = S_FINAL;
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sink_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sink_ff  <= sink_in;
      end
   end

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && status.in_valid) |=> state_ff == S_LOOK)
      else $error("accepted item not looked up");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.in_ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |=> state_ff == S_IDLE)
      else $error("final result not followed by idle");

endmodule

// ===== rtl/indexed_timer_min_heap_unit.sv =====
`timescale 1ns / 1ps
// Unknown id, full heap, clear and unused codes pass lookup and dispatch straight to the result;
// add, update and fire sift the heap one level per step; expire reports due timers one at a time,
// removing each from the heap; the result register may wait on the sink.
// Throughput: one item in flight; the next is accepted the cycle after its last result.
// Reset: synchronous; heap count and presence bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// indexed_timer_min_heap_unit
// Indexed binary min-heap timer queue: add, update, fire, expire, clear.
// ----------------------------------------------------------------------------
module indexed_timer_min_heap_unit #(
   parameter int HEAP_CAPACITY = itmh_pkg::HEAP_CAPACITY,
   parameter int ID_SPACE      = itmh_pkg::ID_SPACE
) (
   input logic        clock,
   input logic        reset,
   itmh_req_if.sink   req,
   itmh_rsp_if.source rsp
);

   itmh_pkg::cmd_type    cmd;
   itmh_pkg::status_type status;

   itmh_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   itmh_datapath #(
      .HEAP_CAPACITY (HEAP_CAPACITY),
      .ID_SPACE      (ID_SPACE)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .cmd    (cmd),
      .status (status)
   );

endmodule
